// ===== rtl/core/scan_channel_sample_unpacker_unit_defines.svh =====
// Assertion macros shared by the scan channel sample unpacker RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef SCAN_CHANNEL_SAMPLE_UNPACKER_UNIT_DEFINES_SVH
`define SCAN_CHANNEL_SAMPLE_UNPACKER_UNIT_DEFINES_SVH
`ifndef SYNTH
// A property checked at every clock edge outside reset.
`define SCSU_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);
// A condition that must be followed by another in the next cycle.
`define SCSU_ASSERT_NEXT(name, clk, rst, cond, nxt, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
    else $error(msg);
`else
`define SCSU_ASSERT(name, clk, rst, prop, msg)
`define SCSU_ASSERT_NEXT(name, clk, rst, cond, nxt, msg)
`endif
`endif

// ===== rtl/core/scsu_pkg.sv =====
// Shared types, constants and a helper function of the scan channel sample unpacker.
// No dependencies; used by every module of the block.
package scsu_pkg;

  // Fixed field widths.
  localparam int NUM_CH       = 8;
  localparam int CHAN_W       = 3;
  localparam int WORD_W       = 32;
  localparam int SAMPLE_W     = 33;
  localparam int IDX_W        = 16;
  localparam int LEN_W        = 17;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 48;

  // Defaults for the top level parameters.
  localparam int MAX_CHANNELS_DEF = 8;
  localparam int RING_DEPTH_DEF   = 65536;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam logic [LEN_W-1:0] RING_LEN_RESET = 17'd400;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIG_END  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFTS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTHS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RING_LEN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_START    = 3'd7;

  // Sample size codes.
  localparam logic [1:0] SIZE_ONE  = 2'd0;
  localparam logic [1:0] SIZE_TWO  = 2'd1;
  localparam logic [1:0] SIZE_FOUR = 2'd2;
  localparam logic [1:0] SIZE_SKIP = 2'd3;

  // Per-channel table.
  typedef struct packed {
    logic [7:0]  enable;
    logic [15:0] size_codes;
    logic [7:0]  big_endian;
    logic [7:0]  sign_ext;
    logic [39:0] shifts;
    logic [47:0] widths;
  } chan_cfg_t;

  // One gathered word on its way from the front to the back.
  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [CHAN_W-1:0] slot;
    logic [IDX_W-1:0]  ring_idx;
    logic [WORD_W-1:0] word;
    logic              eos;
  } entry_t;

  // Status of the ring index recompute unit.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] so_mod;
  } ring_stat_t;

  // First active channel at or after a position; NUM_CH when there is none.
  function automatic logic [CHAN_W:0] find_from(input logic [NUM_CH-1:0] act,
                                                input logic [CHAN_W:0] from);
    logic [CHAN_W:0] r;
    r = (CHAN_W+1)'(NUM_CH);
    for (int c = NUM_CH - 1; c >= 0; c--) begin
      if (act[c] && (c >= int'(from))) begin
        r = (CHAN_W+1)'(c);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/scsu_queue.sv =====
// Short register queue that decouples the byte front from the sample back.
// Depends on scsu_pkg for the entry type.
`include "scan_channel_sample_unpacker_unit_defines.svh"
module scsu_queue #(
  parameter int DEPTH = scsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  scsu_pkg::entry_t wr_data,
  input  logic             rd,
  output scsu_pkg::entry_t head,
  output logic             q_empty,
  output logic             q_full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  scsu_pkg::entry_t  mem [DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [CNT_W-1:0]  count;

  // Storage, no reset needed.
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wr_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (wr && !rd) begin
        count <= count + CNT_W'(1);
      end else if (rd && !wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign head    = mem[rptr];
  assign q_empty = (count == '0);
  assign q_full  = (count == CNT_W'(DEPTH));

  `SCSU_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(DEPTH), "queue overflow")
  `SCSU_ASSERT(a_no_underflow, clk, rst, rd |-> (count != '0), "read from empty queue")

endmodule

// ===== rtl/core/scsu_front.sv =====
// Byte front: walks the channel table, gathers bytes into words and tracks the scan.
// Depends on scsu_pkg; feeds scsu_queue and takes status from scsu_ring_mod.
`include "scan_channel_sample_unpacker_unit_defines.svh"
module scsu_front #(
  parameter int MAX_CHANNELS = scsu_pkg::MAX_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [7:0]                    data_byte,
  output logic                          full,
  input  scsu_pkg::chan_cfg_t           cfg,
  input  logic [scsu_pkg::LEN_W-1:0]    ring_len,
  input  scsu_pkg::ring_stat_t          ring_stat,
  output logic [scsu_pkg::IDX_W-1:0]    scan_count,
  input  logic                          q_full,
  output logic                          q_wr,
  output scsu_pkg::entry_t              q_data
);

  localparam int CW = scsu_pkg::CHAN_W;
  localparam int NC = scsu_pkg::NUM_CH;
  localparam int IW = scsu_pkg::IDX_W;
  localparam int LW = scsu_pkg::LEN_W;
  localparam int WW = scsu_pkg::WORD_W;

  logic [CW-1:0] table_position;
  logic [1:0]    bytes_gathered;
  logic [WW-1:0] assembly_word;
  logic [CW-1:0] active_slot;
  logic [IW-1:0] ring_idx;
  logic [IW-1:0] so_mod;

  logic [NC-1:0] act;
  logic [CW:0]   f_cur;
  logic [CW:0]   f_first;
  logic [CW:0]   f_next;
  logic          none_active;
  logic          wrap;
  logic [CW-1:0] p;
  logic [1:0]    count;
  logic [CW-1:0] cur_slot;
  logic [1:0]    code;
  logic          done;
  logic [WW-1:0] base;
  logic [WW-1:0] word;
  logic          accept;
  logic [LW-1:0] sc_inc;
  logic [LW-1:0] idx_inc;

  // Channels that take part in the scan.
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      act[c] = (c < MAX_CHANNELS) && cfg.enable[c] &&
               (cfg.size_codes[2*c +: 2] != scsu_pkg::SIZE_SKIP);
    end
  end

  // Pick the channel this byte belongs to.
  always_comb begin
    f_cur       = scsu_pkg::find_from(act, {1'b0, table_position});
    f_first     = scsu_pkg::find_from(act, '0);
    none_active = f_first[CW];
    wrap        = f_cur[CW];
    p           = wrap ? f_first[CW-1:0] : f_cur[CW-1:0];
    count       = (wrap || (f_cur[CW-1:0] != table_position)) ? 2'd0 : bytes_gathered;
    cur_slot    = wrap ? '0 : active_slot;
    code        = cfg.size_codes[2*int'(p) +: 2];
    f_next      = scsu_pkg::find_from(act, {1'b0, p} + (CW+1)'(1));
  end

  // Byte assembly and end of sample.
  always_comb begin
    case (code)
      scsu_pkg::SIZE_ONE: done = 1'b1;
      scsu_pkg::SIZE_TWO: done = (count >= 2'd1);
      default:            done = (count == 2'd3);
    endcase
    base = (count == 2'd0) ? '0 : assembly_word;
    if (cfg.big_endian[p]) begin
      word = {base[WW-9:0], data_byte};
    end else begin
      word = base | ({{(WW-8){1'b0}}, data_byte} << {count, 3'b000});
    end
  end

  assign full    = q_full || ring_stat.busy;
  assign accept  = push && !full;
  assign sc_inc  = {1'b0, scan_count} + LW'(1);
  assign idx_inc = {1'b0, ring_idx} + LW'(1);

  // Walk and scan state.
  always_ff @(posedge clk) begin
    if (rst) begin
      table_position <= '0;
      bytes_gathered <= '0;
      assembly_word  <= '0;
      active_slot    <= '0;
      scan_count     <= '0;
      ring_idx       <= '0;
      so_mod         <= '0;
    end else if (ring_stat.done) begin
      ring_idx <= ring_stat.idx;
      so_mod   <= ring_stat.so_mod;
    end else if (accept) begin
      if (none_active) begin
        bytes_gathered <= '0;
        assembly_word  <= '0;
      end else if (!done) begin
        bytes_gathered <= count + 2'd1;
        table_position <= p;
        assembly_word  <= word;
        active_slot    <= cur_slot;
      end else begin
        bytes_gathered <= '0;
        assembly_word  <= word;
        if (f_next[CW]) begin
          table_position <= f_first[CW-1:0];
          active_slot    <= '0;
          if (sc_inc >= ring_len) begin
            scan_count <= '0;
            ring_idx   <= so_mod;
          end else begin
            scan_count <= sc_inc[IW-1:0];
            ring_idx   <= (idx_inc == ring_len) ? '0 : idx_inc[IW-1:0];
          end
        end else begin
          table_position <= f_next[CW-1:0];
          active_slot    <= cur_slot + CW'(1);
        end
      end
    end
  end

  // Hand a finished word to the queue.
  assign q_wr          = accept && !none_active && done;
  assign q_data.chan     = p;
  assign q_data.slot     = cur_slot;
  assign q_data.ring_idx = ring_idx;
  assign q_data.word     = word;
  assign q_data.eos      = f_next[CW];

  `SCSU_ASSERT(a_wr_has_room, clk, rst, q_wr |-> !q_full, "front wrote into a full queue")

endmodule

// ===== rtl/core/scsu_ring_mod.sv =====
// Ring index recompute: reduces start offset and offset plus scan count modulo
// the ring length, one quotient bit per cycle. Depends on scsu_pkg.
`include "scan_channel_sample_unpacker_unit_defines.svh"
module scsu_ring_mod (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [scsu_pkg::IDX_W-1:0] start_offset,
  input  logic [scsu_pkg::IDX_W-1:0] scan_count,
  input  logic [scsu_pkg::LEN_W-1:0] ring_len,
  output scsu_pkg::ring_stat_t       stat
);

  localparam int LW     = scsu_pkg::LEN_W;
  localparam int IW     = scsu_pkg::IDX_W;
  localparam int CNT_W  = $clog2(LW + 2);
  localparam logic [CNT_W-1:0] ST_IDLE = '0;
  localparam logic [CNT_W-1:0] ST_LOAD = CNT_W'(LW + 1);
  localparam logic [CNT_W-1:0] ST_LAST = CNT_W'(1);

  logic [CNT_W-1:0] state;
  logic [LW-1:0]    xa;
  logic [LW-1:0]    xb;
  logic [LW-1:0]    ra;
  logic [LW-1:0]    rb;
  logic             done_q;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  function automatic logic [LW-1:0] mod_step(input logic [LW-1:0] r,
                                             input logic bit_in,
                                             input logic [LW-1:0] d);
    logic [LW-1:0] t;
    t = {r[LW-2:0], bit_in};
    return (t >= d) ? (t - d) : t;
  endfunction

  // Sequencer: load, then one step per cycle for every dividend bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= (state == ST_LAST);
      if (start) begin
        state <= ST_LOAD;
      end else if (state != ST_IDLE) begin
        state <= state - CNT_W'(1);
      end
    end
  end

  // Remainder datapath.
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      xa <= {1'b0, start_offset};
      xb <= {1'b0, start_offset} + {1'b0, scan_count};
      ra <= '0;
      rb <= '0;
    end else if (state != ST_IDLE) begin
      xa <= {xa[LW-2:0], 1'b0};
      xb <= {xb[LW-2:0], 1'b0};
      ra <= mod_step(ra, xa[LW-1], ring_len);
      rb <= mod_step(rb, xb[LW-1], ring_len);
    end
  end

  assign stat.busy   = (state != ST_IDLE) || done_q;
  assign stat.done   = done_q;
  assign stat.idx    = rb[IW-1:0];
  assign stat.so_mod = ra[IW-1:0];

  `SCSU_ASSERT_NEXT(a_start_busy, clk, rst, start, stat.busy, "recompute did not start")

endmodule

// ===== rtl/core/scsu_back.sv =====
// Sample back: shifts, masks and sign-extends a gathered word into the result register.
// Depends on scsu_pkg; reads entries from scsu_queue.
module scsu_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  scsu_pkg::chan_cfg_t                  cfg,
  input  scsu_pkg::entry_t                     head,
  input  logic                                 q_empty,
  output logic                                 q_rd,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [scsu_pkg::CHAN_W-1:0]          out_slot,
  output logic [scsu_pkg::IDX_W-1:0]           ring_index,
  output logic signed [scsu_pkg::SAMPLE_W-1:0] sample_value,
  output logic                                 end_of_scan
);

  localparam int WW = scsu_pkg::WORD_W;

  logic                                 out_valid;
  logic [scsu_pkg::CHAN_W-1:0]          slot_q;
  logic [scsu_pkg::IDX_W-1:0]           idx_q;
  logic signed [scsu_pkg::SAMPLE_W-1:0] sample_q;
  logic                                 eos_q;

  logic [4:0]                           sh;
  logic [5:0]                           w_raw;
  logic [5:0]                           w_use;
  logic [WW-1:0]                        mask;
  logic [WW-1:0]                        v;
  logic                                 neg;
  logic [scsu_pkg::SAMPLE_W-1:0]        sample;

  // Shift, mask and sign extension of the head word.
  always_comb begin
    sh     = cfg.shifts[5*int'(head.chan) +: 5];
    w_raw  = cfg.widths[6*int'(head.chan) +: 6];
    w_use  = ((w_raw == 6'd0) || (w_raw > 6'd32)) ? 6'd32 : w_raw;
    mask   = {WW{1'b1}} >> (6'd32 - w_use);
    v      = (head.word >> sh) & mask;
    neg    = cfg.sign_ext[head.chan] && v[5'(w_use - 6'd1)];
    sample = neg ? {1'b1, v | ~mask} : {1'b0, v};
  end

  // The output register refills whenever it is empty or being taken.
  assign q_rd = !q_empty && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_rd) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      slot_q   <= head.slot;
      idx_q    <= head.ring_idx;
      sample_q <= $signed(sample);
      eos_q    <= head.eos;
    end
  end

  assign empty        = !out_valid;
  assign out_slot     = slot_q;
  assign ring_index   = idx_q;
  assign sample_value = sample_q;
  assign end_of_scan  = eos_q;

endmodule

// ===== rtl/core/scan_channel_sample_unpacker_unit.sv =====
// Scan channel sample unpacker: one byte per cycle in while full is low, one sample
// per completed word out; each word passes the queue, then the result register.
// Throughput: 1 byte per cycle unless the queue between byte front and sample back is full.
// A write to ring_length or start_offset holds full high while the
// ring index is recomputed, one remainder bit per cycle.
// Reset (synchronous): walk and scan state cleared, registers to reset values, no sweep.
`include "scan_channel_sample_unpacker_unit_defines.svh"
module scan_channel_sample_unpacker_unit #(
  parameter int MAX_CHANNELS = scsu_pkg::MAX_CHANNELS_DEF,
  parameter int RING_DEPTH   = scsu_pkg::RING_DEPTH_DEF,
  parameter int QUEUE_DEPTH  = scsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic [7:0]                             data_byte,
  output logic                                   empty,
  input  logic                                   pop,
  output logic [scsu_pkg::CHAN_W-1:0]            out_slot,
  output logic [scsu_pkg::IDX_W-1:0]             ring_index,
  output logic signed [scsu_pkg::SAMPLE_W-1:0]   sample_value,
  output logic                                   end_of_scan,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [scsu_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [scsu_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int LW = scsu_pkg::LEN_W;
  localparam int IW = scsu_pkg::IDX_W;

  scsu_pkg::chan_cfg_t  cfg;
  logic [LW-1:0]        ring_length;
  logic [IW-1:0]        start_offset;
  logic [LW-1:0]        ring_len_eff;
  logic                 cfg_we;
  logic                 ring_start;
  scsu_pkg::ring_stat_t ring_stat;
  logic [IW-1:0]        scan_count;
  logic                 q_wr;
  logic                 q_rd;
  logic                 q_empty;
  logic                 q_full;
  scsu_pkg::entry_t     q_data;
  scsu_pkg::entry_t     q_head;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg          <= '0;
      ring_length  <= scsu_pkg::RING_LEN_RESET;
      start_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        scsu_pkg::REG_ENABLE:   cfg.enable     <= cfg_data[7:0];
        scsu_pkg::REG_SIZE:     cfg.size_codes <= cfg_data[15:0];
        scsu_pkg::REG_BIG_END:  cfg.big_endian <= cfg_data[7:0];
        scsu_pkg::REG_SIGNED:   cfg.sign_ext   <= cfg_data[7:0];
        scsu_pkg::REG_SHIFTS:   cfg.shifts     <= cfg_data[39:0];
        scsu_pkg::REG_WIDTHS:   cfg.widths     <= cfg_data[47:0];
        scsu_pkg::REG_RING_LEN: ring_length    <= cfg_data[LW-1:0];
        scsu_pkg::REG_START:    start_offset   <= cfg_data[IW-1:0];
        default: ;
      endcase
    end
  end

  // A new length or offset invalidates the running ring index.
  assign ring_start = cfg_we &&
                      (cfg_index inside {scsu_pkg::REG_RING_LEN, scsu_pkg::REG_START});

  // Ring length clamped to the usable range.
  always_comb begin
    if (ring_length == '0) begin
      ring_len_eff = LW'(1);
    end else if (ring_length > LW'(RING_DEPTH)) begin
      ring_len_eff = LW'(RING_DEPTH);
    end else begin
      ring_len_eff = ring_length;
    end
  end

  scsu_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .data_byte  (data_byte),
    .full       (full),
    .cfg        (cfg),
    .ring_len   (ring_len_eff),
    .ring_stat  (ring_stat),
    .scan_count (scan_count),
    .q_full     (q_full),
    .q_wr       (q_wr),
    .q_data     (q_data)
  );

  scsu_ring_mod u_ring_mod (
    .clk          (clk),
    .rst          (rst),
    .start        (ring_start),
    .start_offset (start_offset),
    .scan_count   (scan_count),
    .ring_len     (ring_len_eff),
    .stat         (ring_stat)
  );

  scsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_data),
    .rd      (q_rd),
    .head    (q_head),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  scsu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (q_head),
    .q_empty      (q_empty),
    .q_rd         (q_rd),
    .empty        (empty),
    .pop          (pop),
    .out_slot     (out_slot),
    .ring_index   (ring_index),
    .sample_value (sample_value),
    .end_of_scan  (end_of_scan)
  );

  `SCSU_ASSERT(a_no_accept_busy, clk, rst, push && !full |-> !ring_stat.busy, "busy accept")

endmodule
